>>> hw/rtl/slri_pkg.sv
package slri_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int VALUE_W       = 32;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic                      ins_en;
      logic                      rem_en;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/sorted_list_insert_remove.sv
// Sorted list of signed values held in a row of compare-and-shift cells.
// The result strobe is registered and rises in the cycle after the request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in parallel.
// busy is high only while reset is asserted; the receiver cannot stall.
// Synchronous active-high reset clears the count and the result strobe;
// entry contents are not cleared and are read only below the count.
module sorted_list_insert_remove #(
   parameter int CAPACITY = slri_pkg::CAPACITY_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic                                      req_opcode,
   input  logic signed [slri_pkg::VALUE_W-1:0]       req_value,
   output logic                                      rsp_valid,
   output logic [1:0]                                rsp_status,
   output logic signed [slri_pkg::VALUE_W-1:0]       rsp_echoed_value,
   output logic [slri_pkg::ENTRY_COUNT_W-1:0]        rsp_entry_count,
   output logic signed [slri_pkg::VALUE_W-1:0]       rsp_smallest
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                                      rsp_valid_ff;
   logic [1:0]                                rsp_status_ff;
   logic signed [slri_pkg::VALUE_W-1:0]       rsp_echoed_value_ff;
   logic [slri_pkg::ENTRY_COUNT_W-1:0]        rsp_entry_count_ff;
   logic signed [slri_pkg::VALUE_W-1:0]       rsp_smallest_ff;

   slri_pkg::cell_ctrl_type ctrl;
   slri_pkg::status_type    status;
   logic                    accept;
   logic                    is_ins;
   logic                    is_rem;
   logic                    full;
   logic                    found;
   logic [slri_pkg::ENTRY_COUNT_W-1:0] count_out;

   logic [CAPACITY-1:0]                 lt_w;
   logic [CAPACITY-1:0]                 hit_w;
   logic [CAPACITY-1:0]                 occ_w;
   logic signed [slri_pkg::VALUE_W-1:0] entry_w [CAPACITY];
   logic signed [slri_pkg::VALUE_W-1:0] next_w  [CAPACITY];

   assign busy   = reset;
   assign accept = start && !busy;
   assign is_ins = accept && (req_opcode == slri_pkg::OP_INSERT);
   assign is_rem = accept && (req_opcode == slri_pkg::OP_REMOVE);
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign found  = |hit_w;

   assign ctrl.ins_en = is_ins && !full;
   assign ctrl.rem_en = is_rem && found;
   assign ctrl.value  = req_value;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                                left_lt_s;
         logic signed [slri_pkg::VALUE_W-1:0] left_s;
         logic signed [slri_pkg::VALUE_W-1:0] right_s;

         assign occ_w[gi] = (count_ff > CNT_W'(gi));

         if (gi == 0) begin : g_first
            assign left_lt_s = 1'b1;
            assign left_s    = req_value;
         end else begin : g_mid
            assign left_lt_s = lt_w[gi-1];
            assign left_s    = entry_w[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_s = entry_w[gi];
         end else begin : g_inner
            assign right_s = entry_w[gi+1];
         end

         slri_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occ         (occ_w[gi]),
            .left_lt     (left_lt_s),
            .left_entry  (left_s),
            .right_entry (right_s),
            .lt          (lt_w[gi]),
            .hit         (hit_w[gi]),
            .entry       (entry_w[gi]),
            .next_entry  (next_w[gi])
         );
      end

      if (CNT_W >= slri_pkg::ENTRY_COUNT_W) begin : g_cnt_trunc
         assign count_out = count_in[slri_pkg::ENTRY_COUNT_W-1:0];
      end else begin : g_cnt_ext
         assign count_out = {{(slri_pkg::ENTRY_COUNT_W-CNT_W){1'b0}}, count_in};
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      priority if (ctrl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem_en) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      status = slri_pkg::ST_DONE;
      priority if (is_ins && full) begin
         status = slri_pkg::ST_FULL;
      end else if (is_rem && !found) begin
         status = slri_pkg::ST_NOT_FOUND;
      end else begin
         status = slri_pkg::ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff       <= status;
         rsp_echoed_value_ff <= req_value;
         rsp_entry_count_ff  <= count_out;
         rsp_smallest_ff     <= (count_in == '0) ? '0 : next_w[0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_echoed_value = rsp_echoed_value_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_smallest     = rsp_smallest_ff;

endmodule

>>> hw/rtl/slri_cell.sv
module slri_cell (
   input  logic                                clock,
   input  slri_pkg::cell_ctrl_type             ctrl,
   input  logic                                occ,
   input  logic                                left_lt,
   input  logic signed [slri_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [slri_pkg::VALUE_W-1:0] right_entry,
   output logic                                lt,
   output logic                                hit,
   output logic signed [slri_pkg::VALUE_W-1:0] entry,
   output logic signed [slri_pkg::VALUE_W-1:0] next_entry
);

   logic signed [slri_pkg::VALUE_W-1:0] entry_ff;
   logic signed [slri_pkg::VALUE_W-1:0] entry_in;

   assign lt         = occ && (entry_ff < ctrl.value);
   assign hit        = occ && (entry_ff == ctrl.value) && left_lt;
   assign entry      = entry_ff;
   assign next_entry = entry_in;

   // insert: keep smaller entries, drop value at the boundary, shift the rest up
   // remove: keep smaller entries, pull the rest down from the right
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.ins_en) begin
         if (!lt) begin
            entry_in = left_lt ? ctrl.value : left_entry;
         end
      end else if (ctrl.rem_en) begin
         if (!lt) begin
            entry_in = right_entry;
         end
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
